>>> sv/mhpk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MQTT header / keep-alive package
// Shared types and constants for the fixed-header decoder and ping timer.
// ----------------------------------------------------------------------------
package mhpk_pkg;

  // Input word actions
  typedef enum logic [1:0] {
    ACT_BYTE  = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_START = 2'd2,
    ACT_STOP  = 2'd3
  } action_e;

  // Result word kinds
  typedef enum logic [1:0] {
    KIND_DONE    = 2'd0,
    KIND_LEN_ERR = 2'd1,
    KIND_PING    = 2'd2,
    KIND_TIMEOUT = 2'd3
  } kind_e;

  // Register map (index taken from paddr[2])
  localparam logic REG_PING_IVL  = 1'b0;
  localparam logic REG_RETRY_IVL = 1'b1;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned LEN_W   = 28;
  localparam int unsigned IVL_W   = 16;

  localparam logic [IVL_W-1:0] PING_IVL_RST  = 16'd60;
  localparam logic [IVL_W-1:0] RETRY_IVL_RST = 16'd5;

  // Types 2,3,4,5,6,7,9,11,13 are handled
  localparam logic [15:0] HANDLED_MASK = 16'h2AFC;

  // Retry limit before a timeout is reported
  localparam logic [1:0] MAX_UNANSWERED = 2'd2;

  // One result word
  typedef struct packed {
    kind_e            kind;
    logic [3:0]       packet_type;
    logic [3:0]       packet_flags;
    logic [LEN_W-1:0] remaining_length;
    logic             type_handled;
  } res_t;

endpackage

>>> sv/mhpk_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MQTT keep-alive configuration registers
// APB-style register file holding the ping and retry intervals.
// ----------------------------------------------------------------------------
module mhpk_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mhpk_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output logic [mhpk_pkg::IVL_W-1:0]   ping_ivl_o,
  output logic [mhpk_pkg::IVL_W-1:0]   retry_ivl_o
);
  import mhpk_pkg::*;

  logic             wr_en;
  logic [IVL_W-1:0] ping_ivl_q;
  logic [IVL_W-1:0] retry_ivl_q;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Register writes in the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ping_ivl_q  <= PING_IVL_RST;
      retry_ivl_q <= RETRY_IVL_RST;
    end else if (wr_en) begin
      if (paddr[2] == REG_PING_IVL) begin
        ping_ivl_q <= pwdata[IVL_W-1:0];
      end else begin
        retry_ivl_q <= pwdata[IVL_W-1:0];
      end
    end
  end

  // Read-back
  always_comb begin
    if (paddr[2] == REG_RETRY_IVL) begin
      prdata = {{(32-IVL_W){1'b0}}, retry_ivl_q};
    end else begin
      prdata = {{(32-IVL_W){1'b0}}, ping_ivl_q};
    end
  end

  assign ping_ivl_o  = ping_ivl_q;
  assign retry_ivl_o = retry_ivl_q;

endmodule

>>> sv/mhpk_hdr_dec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MQTT fixed-header decoder
// Captures type and flags from the first byte, then accumulates the
// base-128 remaining length one byte per word.
// ----------------------------------------------------------------------------
module mhpk_hdr_dec #(
  parameter int unsigned MAX_LENGTH_BYTES = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic [7:0]     byte_i,
  output logic           res_valid_o,
  output mhpk_pkg::res_t res_o,
  output logic           hdr_done_o
);
  import mhpk_pkg::*;

  logic             in_len_q, in_len_d;
  logic [3:0]       type_q, type_d;
  logic [3:0]       flags_q, flags_d;
  logic [LEN_W-1:0] acc_q, acc_d;
  logic [2:0]       seen_q, seen_d;
  logic [LEN_W-1:0] grp_shifted;
  logic [LEN_W-1:0] acc_sum;

  // Place the 7-bit group at the position of this length byte
  always_comb begin
    case (seen_q[1:0])
      2'd0:    grp_shifted = {21'd0, byte_i[6:0]};
      2'd1:    grp_shifted = {14'd0, byte_i[6:0], 7'd0};
      2'd2:    grp_shifted = {7'd0, byte_i[6:0], 14'd0};
      default: grp_shifted = {byte_i[6:0], 21'd0};
    endcase
  end

  assign acc_sum = acc_q + grp_shifted;

  // Parser next state and result
  always_comb begin
    in_len_d    = in_len_q;
    type_d      = type_q;
    flags_d     = flags_q;
    acc_d       = acc_q;
    seen_d      = seen_q;
    res_valid_o = 1'b0;
    hdr_done_o  = 1'b0;
    res_o       = '{kind: KIND_DONE, packet_type: type_q, packet_flags: flags_q,
                    remaining_length: acc_sum, type_handled: 1'b0};
    if (en_i) begin
      if (!in_len_q) begin
        type_d   = byte_i[7:4];
        flags_d  = byte_i[3:0];
        acc_d    = '0;
        seen_d   = '0;
        in_len_d = 1'b1;
      end else begin
        acc_d  = acc_sum;
        seen_d = seen_q + 3'd1;
        if (byte_i[7]) begin
          // continuation on the last permitted byte is an overlong length
          if (seen_d >= 3'(MAX_LENGTH_BYTES)) begin
            in_len_d    = 1'b0;
            res_valid_o = 1'b1;
            res_o.kind  = KIND_LEN_ERR;
          end
        end else begin
          in_len_d           = 1'b0;
          res_valid_o        = 1'b1;
          hdr_done_o         = 1'b1;
          res_o.type_handled = HANDLED_MASK[type_q];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_len_q <= 1'b0;
      type_q   <= '0;
      flags_q  <= '0;
      acc_q    <= '0;
      seen_q   <= '0;
    end else begin
      in_len_q <= in_len_d;
      type_q   <= type_d;
      flags_q  <= flags_d;
      acc_q    <= acc_d;
      seen_q   <= seen_d;
    end
  end

  // Byte count inside the length field never reaches the limit
  a_seen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_len_q |-> (seen_q < 3'(MAX_LENGTH_BYTES)))
    else $error("length byte count out of range");

endmodule

>>> sv/mhpk_ka_timer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MQTT keep-alive ping timer
// Tick-driven countdown that requests pings and reports a missing response.
// ----------------------------------------------------------------------------
module mhpk_ka_timer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  mhpk_pkg::action_e          action_i,
  input  logic                       hdr_done_i,
  input  logic [mhpk_pkg::IVL_W-1:0] ping_ivl_i,
  input  logic [mhpk_pkg::IVL_W-1:0] retry_ivl_i,
  output logic                       res_valid_o,
  output mhpk_pkg::res_t             res_o
);
  import mhpk_pkg::*;

  logic [IVL_W-1:0] cd_q, cd_d;
  logic [1:0]       unans_q, unans_d;
  logic             cd_one;

  assign cd_one = (cd_q == IVL_W'(1));

  // Countdown and retry count update
  always_comb begin
    cd_d        = cd_q;
    unans_d     = unans_q;
    res_valid_o = 1'b0;
    res_o       = '{kind: KIND_PING, packet_type: 4'd0, packet_flags: 4'd0,
                    remaining_length: '0, type_handled: 1'b0};
    if (en_i) begin
      case (action_i)
        ACT_BYTE: begin
          if (hdr_done_i) begin
            cd_d    = ping_ivl_i;
            unans_d = '0;
          end
        end
        ACT_TICK: begin
          if (cd_one) begin
            res_valid_o = 1'b1;
            if (unans_q >= MAX_UNANSWERED) begin
              unans_d    = '0;
              cd_d       = '0;
              res_o.kind = KIND_TIMEOUT;
            end else begin
              cd_d    = (unans_q == 2'd0) ? ping_ivl_i : retry_ivl_i;
              unans_d = unans_q + 2'd1;
            end
          end else if (cd_q != '0) begin
            cd_d = cd_q - IVL_W'(1);
          end
        end
        ACT_START: begin
          cd_d    = ping_ivl_i;
          unans_d = '0;
        end
        default: begin
          cd_d = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cd_q    <= '0;
      unans_q <= '0;
    end else begin
      cd_q    <= cd_d;
      unans_q <= unans_d;
    end
  end

  // Retry count never exceeds the limit
  a_unans_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unans_q <= MAX_UNANSWERED)
    else $error("unanswered ping count beyond limit");

  // A timeout stops the timer
  a_timeout_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && action_i == ACT_TICK && cd_one && unans_q == MAX_UNANSWERED)
      |=> (cd_q == '0 && unans_q == 2'd0))
    else $error("timer still running after timeout");

endmodule

>>> sv/mqtt_header_parse_keepalive_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MQTT fixed-header decoder with keep-alive timer
// Top level: input register, single-pass decode, result register.
// ----------------------------------------------------------------------------
// Each input word (a received byte, a timer tick, a start or a stop) is
// captured in an input register and decoded combinationally into at most one
// result word held in an output register. One word is taken every clock
// unless the result register is still waiting on out_ready_i; a result
// passes the input register and then the result register before it is shown.
// The rate is set by the header/timer update; in_ready_o follows out_ready_i
// combinationally when both registers are full. Words that produce no result
// still pass through the input register but load no result. The two interval
// registers sit on an APB-style port at byte addresses 0 and 4 and should be
// written only while the block is idle.
module mqtt_header_parse_keepalive_top #(
  parameter int unsigned MAX_LENGTH_BYTES = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input words
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   action_i,
  input  logic [7:0]                   rx_byte_i,
  // result words
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   kind_o,
  output logic [3:0]                   packet_type_o,
  output logic [3:0]                   packet_flags_o,
  output logic [27:0]                  remaining_length_o,
  output logic                         type_handled_o,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mhpk_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import mhpk_pkg::*;

  logic             s1_valid_q;
  action_e          s1_action_q;
  logic [7:0]       s1_byte_q;
  logic             out_free;
  logic             proc;
  logic [IVL_W-1:0] ping_ivl;
  logic [IVL_W-1:0] retry_ivl;
  logic             hdr_v, ka_v, hdr_done;
  res_t             hdr_res, ka_res;
  logic             out_valid_q;
  res_t             out_q;

  // Handshake: the stage advances when the result register can take a word
  assign out_free   = !out_valid_q || out_ready_i;
  assign proc       = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || proc;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_action_q <= action_e'(action_i);
      s1_byte_q   <= rx_byte_i;
    end
  end

  mhpk_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .ping_ivl_o  (ping_ivl),
    .retry_ivl_o (retry_ivl)
  );

  mhpk_hdr_dec #(
    .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
  ) u_hdr_dec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (proc && s1_action_q == ACT_BYTE),
    .byte_i      (s1_byte_q),
    .res_valid_o (hdr_v),
    .res_o       (hdr_res),
    .hdr_done_o  (hdr_done)
  );

  mhpk_ka_timer u_ka_timer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (proc),
    .action_i    (s1_action_q),
    .hdr_done_i  (hdr_done),
    .ping_ivl_i  (ping_ivl),
    .retry_ivl_i (retry_ivl),
    .res_valid_o (ka_v),
    .res_o       (ka_res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= proc && (hdr_v || ka_v);
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && (hdr_v || ka_v)) begin
      out_q <= hdr_v ? hdr_res : ka_res;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign kind_o             = out_q.kind;
  assign packet_type_o      = out_q.packet_type;
  assign packet_flags_o     = out_q.packet_flags;
  assign remaining_length_o = out_q.remaining_length;
  assign type_handled_o     = out_q.type_handled;

  // Parser and timer never both produce a word for the same input
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(hdr_v && ka_v))
    else $error("two results for one input word");

  // A held input word is not dropped while the result side stalls
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !proc) |=> s1_valid_q)
    else $error("input word lost while stalled");

endmodule
